[design/pfaba_pkg.sv]
// ----------------------------------------------------------------------------
// pfaba_pkg
// Shared types, constants and helpers of the per-frame aligned bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfaba_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int FRAMES_W   = $clog2(MAX_FRAMES + 1);

	localparam int ALIGN_W    = 9;
	localparam int MASK_W     = ALIGN_W - 1;
	localparam int SLICE_W    = 29;
	localparam int FIELD_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;
	localparam int FRAME_W    = 3;
	localparam int COUNT_W    = 29;
	localparam int ROUND_W    = COUNT_W + 1;
	localparam int SUM_W      = SLICE_W + 2;
	localparam int BASE_W     = 32;
	localparam int OFFSET_W   = 31;

	localparam logic [SLICE_W-1:0] SLICE_CAP = SLICE_W'(268435456);

	localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = ALIGN_W'(256);
	localparam logic [SLICE_W-1:0]  SLICE_RESET  = SLICE_W'(65536);
	localparam logic [FIELD_W-1:0]  FRAMES_RESET = FIELD_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALIGNMENT     = 2'd0,
		CFG_SLICE_BYTES   = 2'd1,
		CFG_FRAMES_IN_USE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_FRAME = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	// Mask of the largest power of two not above a; zero counts as one.
	function automatic logic [MASK_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 1; i < ALIGN_W; i++) begin
			if (a[i])
				m = MASK_W'((ALIGN_W'(1) << i) - ALIGN_W'(1));
		end
		return m;
	endfunction

	function automatic logic [SLICE_W-1:0] eff_slice(input logic [SLICE_W-1:0] s);
		return (s > SLICE_CAP) ? SLICE_CAP : s;
	endfunction

	function automatic logic [FRAMES_W-1:0] eff_frames(input logic [FIELD_W-1:0] f);
		logic [FRAMES_W-1:0] r;
		r = FRAMES_W'(f);
		if (f == '0)
			r = FRAMES_W'(1);
		else if (32'(f) > MAX_FRAMES)
			r = FRAMES_W'(MAX_FRAMES);
		return r;
	endfunction

endpackage

`default_nettype wire

[design/per_frame_aligned_bump_allocator.sv]
// ----------------------------------------------------------------------------
// per_frame_aligned_bump_allocator
// Hands out aligned byte ranges from equal per-frame slices of one buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with mode, frame_index and byte_count.
//   An allocate request rounds byte_count up to the alignment and, if it fits
//   in the frame's slice, returns its offset from the buffer start and bumps
//   that frame's fill pointer. A release request zeroes the frame's pointer.
//   Each request yields one result on out_valid/out_ready (status, offset).
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while the
//   block is idle; writes to an index past the register list are ignored.
//   An accepted request is captured in the first-stage registers, and its
//   result in the second-stage result register. Throughput: one request
//   per cycle while the receiver does not stall. The second stage does the
//   fill pointer read-modify-write of a request, so the next request sees it.
//   When the receiver stalls, the result register and the first stage hold,
//   and in_ready drops once both are full.
//   Reset clears all fill pointers, both stage valids, and loads the register
//   defaults (alignment 256, 65536-byte slices, eight frames).
// ----------------------------------------------------------------------------
`default_nettype none

module per_frame_aligned_bump_allocator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [pfaba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfaba_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic [pfaba_pkg::FRAME_W-1:0]       frame_index,
	input  wire logic [pfaba_pkg::COUNT_W-1:0]       byte_count,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic [pfaba_pkg::OFFSET_W-1:0]           byte_offset
);

	logic [pfaba_pkg::ALIGN_W-1:0]  alignment_q;
	logic [pfaba_pkg::SLICE_W-1:0]  slice_bytes_q;
	logic [pfaba_pkg::FIELD_W-1:0]  frames_in_use_q;

	logic [pfaba_pkg::SLICE_W-1:0]  fill_q [pfaba_pkg::MAX_FRAMES];

	logic                           valid_s1;
	pfaba_pkg::mode_t               mode_s1;
	logic [pfaba_pkg::FRAME_W-1:0]  idx_s1;
	logic                           bad_frame_s1;
	logic [pfaba_pkg::ROUND_W-1:0]  rounded_s1;
	logic [pfaba_pkg::SLICE_W-1:0]  slice_s1;
	logic [pfaba_pkg::BASE_W-1:0]   base_s1;

	logic                           out_valid_q;
	pfaba_pkg::status_t             status_q;
	logic [pfaba_pkg::OFFSET_W-1:0] offset_q;

	logic                           advance;
	logic                           accept;
	logic [pfaba_pkg::MASK_W-1:0]   mask;
	logic [pfaba_pkg::ROUND_W-1:0]  count_up;
	logic [pfaba_pkg::SLICE_W-1:0]  fill;
	logic [pfaba_pkg::SUM_W-1:0]    sum;
	logic [pfaba_pkg::BASE_W-1:0]   off;
	logic                           grant;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	assign mask     = pfaba_pkg::align_mask(alignment_q);
	assign count_up = pfaba_pkg::ROUND_W'(byte_count) + pfaba_pkg::ROUND_W'(mask);

	assign fill  = fill_q[idx_s1];
	assign sum   = pfaba_pkg::SUM_W'(fill) + pfaba_pkg::SUM_W'(rounded_s1);
	assign off   = pfaba_pkg::BASE_W'(fill) + base_s1;
	assign grant = (sum <= pfaba_pkg::SUM_W'(slice_s1)) && !off[pfaba_pkg::BASE_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alignment_q     <= pfaba_pkg::ALIGN_RESET;
			slice_bytes_q   <= pfaba_pkg::SLICE_RESET;
			frames_in_use_q <= pfaba_pkg::FRAMES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfaba_pkg::CFG_ALIGNMENT:
					alignment_q <= cfg_data[pfaba_pkg::ALIGN_W-1:0];
				pfaba_pkg::CFG_SLICE_BYTES:
					slice_bytes_q <= cfg_data[pfaba_pkg::SLICE_W-1:0];
				pfaba_pkg::CFG_FRAMES_IN_USE:
					frames_in_use_q <= cfg_data[pfaba_pkg::FIELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage 1: capture request, round count, precompute slice base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= pfaba_pkg::mode_t'(mode);
			idx_s1       <= frame_index;
			bad_frame_s1 <= pfaba_pkg::FRAMES_W'(frame_index)
				>= pfaba_pkg::eff_frames(frames_in_use_q);
			rounded_s1   <= count_up & ~pfaba_pkg::ROUND_W'(mask);
			slice_s1     <= pfaba_pkg::eff_slice(slice_bytes_q);
			base_s1      <= pfaba_pkg::BASE_W'(frame_index)
				* pfaba_pkg::BASE_W'(pfaba_pkg::eff_slice(slice_bytes_q));
		end
	end

	// Stage 2: fill pointer read-modify-write and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < pfaba_pkg::MAX_FRAMES; i++)
				fill_q[i] <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (!bad_frame_s1) begin
					if (mode_s1 == pfaba_pkg::MODE_RELEASE)
						fill_q[idx_s1] <= '0;
					else if (grant)
						fill_q[idx_s1] <= sum[pfaba_pkg::SLICE_W-1:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (bad_frame_s1) begin
				status_q <= pfaba_pkg::ST_BAD_FRAME;
				offset_q <= '0;
			end else if (mode_s1 == pfaba_pkg::MODE_RELEASE) begin
				status_q <= pfaba_pkg::ST_OK;
				offset_q <= '0;
			end else if (grant) begin
				status_q <= pfaba_pkg::ST_OK;
				offset_q <= off[pfaba_pkg::OFFSET_W-1:0];
			end else begin
				status_q <= pfaba_pkg::ST_NO_SPACE;
				offset_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign byte_offset = offset_q;

endmodule

`default_nettype wire

[design/pfaba_checker.sv]
// ----------------------------------------------------------------------------
// pfaba_checker
// Port-level checks of the per-frame aligned bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module pfaba_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic [1:0]                          status,
	input  wire logic [pfaba_pkg::OFFSET_W-1:0]      byte_offset
);

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_offset))
		else $error("result changed while stalled");

	a_backpressure_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request blocked without an output stall");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == pfaba_pkg::ST_OK || status == pfaba_pkg::ST_NO_SPACE
			|| status == pfaba_pkg::ST_BAD_FRAME)
		else $error("illegal status code");

	a_offset_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pfaba_pkg::ST_OK |-> byte_offset == '0)
		else $error("nonzero offset on failed request");

endmodule

bind per_frame_aligned_bump_allocator pfaba_checker u_pfaba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.byte_offset (byte_offset)
);

`default_nettype wire
